// File: rtl/core/hfmc_pkg.sv
// Shared constants and stage tag types for the height-field mean curvature pipeline.
package hfmc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int RAW_WIDTH_DEF = 48;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 32;

    localparam logic [4:0] NORM_SHIFT_RST = 5'd16;

    typedef struct packed {
        logic        num_pos;
        logic        sat;
        logic [62:0] nm;
        logic [47:0] pq;
    } t_sq_tag;

    typedef struct packed {
        logic        num_pos;
        logic        sat;
        logic        big;
        logic [47:0] pq;
    } t_div_tag;

endpackage

// File: rtl/core/height_field_mean_curvature.sv
// Top level: pipelined mean curvature of a height field, one grid point per clock.
//
//  channel | direction | transfer when       | payload
//  --------+-----------+---------------------+-------------------------------------------
//  input   | in        | i_start && !o_busy  | i_slope_x/y_raw, i_second_xx/xy/yy_raw
//  result  | out       | o_done              | o_curvature, o_slope_factor, o_saturated
//  config  | in        | i_cfg_we            | i_cfg_wdata (norm_shift)
//
// One point enters per cycle; o_busy is always low. The pipeline is built from:
// 6 front stages, 32 square root stages, 3 denominator stages, 32 divider stages, output.
// The square root and divider, one bit per stage, set the depth.
// Reset (synchronous, active low) clears valid bits and sets norm_shift to 16.
// The result side cannot stall, so the pipeline advances every cycle.
module height_field_mean_curvature #(
    parameter int RAW_WIDTH = hfmc_pkg::RAW_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic [4:0]                  i_cfg_wdata,
    input  logic signed [RAW_WIDTH-1:0] i_slope_x_raw,
    input  logic signed [RAW_WIDTH-1:0] i_slope_y_raw,
    input  logic signed [RAW_WIDTH-1:0] i_second_xx_raw,
    input  logic signed [RAW_WIDTH-1:0] i_second_xy_raw,
    input  logic signed [RAW_WIDTH-1:0] i_second_yy_raw,
    output logic                        o_done,
    output logic signed [31:0]          o_curvature,
    output logic [31:0]                 o_slope_factor,
    output logic                        o_saturated
);

    localparam int FB = hfmc_pkg::FRAC_BITS;
    localparam logic signed [65:0] S63_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] S63_NEG = -S63_MAX;

    function automatic logic [31:0] mag32(input logic [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    logic [4:0] r_norm_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_shift <= hfmc_pkg::NORM_SHIFT_RST;
        end else if (i_cfg_we) begin
            r_norm_shift <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    // stage 1: normalize and clip
    logic signed [RAW_WIDTH-1:0] raw      [5];
    logic signed [RAW_WIDTH-1:0] s1_shift [5];
    logic [31:0]                 n1_h     [5];
    logic [4:0]                  n1_clip;

    assign raw[0] = i_slope_x_raw;
    assign raw[1] = i_slope_y_raw;
    assign raw[2] = i_second_xx_raw;
    assign raw[3] = i_second_xy_raw;
    assign raw[4] = i_second_yy_raw;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            s1_shift[i] = raw[i] >>> r_norm_shift;
            if (s1_shift[i][RAW_WIDTH-1:31] == {(RAW_WIDTH-31){s1_shift[i][31]}}) begin
                n1_h[i]    = s1_shift[i][31:0];
                n1_clip[i] = 1'b0;
            end else begin
                n1_h[i]    = s1_shift[i][RAW_WIDTH-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n1_clip[i] = 1'b1;
            end
        end
    end

    logic [31:0] r1_h [5];
    logic        r1_sat;

    // stage 2: squares and slope cross product
    logic [31:0] s2_m [5];

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            s2_m[i] = mag32(r1_h[i]);
        end
    end

    logic [63:0] r2_hx2, r2_hy2, r2_hxhy;
    logic        r2_hxhy_neg;
    logic [31:0] r2_m   [3];
    logic        r2_neg [3];
    logic        r2_sat;

    // stage 3: p and the 1+h^2 factors
    logic [63:0] r3_p2;
    logic [46:0] r3_a   [3];
    logic [31:0] r3_m   [3];
    logic        r3_neg [3];
    logic        r3_sat;

    // stage 4: split products
    logic [62:0] r4_pph [3];
    logic [47:0] r4_ppl [3];
    logic        r4_neg [3];
    logic [63:0] r4_p2;
    logic        r4_sat;

    // stage 5: signed terms
    logic [63:0]        s5_mag [3];
    logic [63:0]        s5_val [3];
    logic signed [63:0] n5_t   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s5_mag[i] = 64'(r4_pph[i]) + 64'(r4_ppl[i] >> FB);
            s5_val[i] = (i == 1) ? (s5_mag[i] << 1) : s5_mag[i];
            n5_t[i]   = r4_neg[i] ? -s5_val[i] : s5_val[i];
        end
    end

    logic signed [63:0] r5_t [3];
    logic [63:0]        r5_p2;
    logic               r5_sat;

    // stage 6: numerator sum and clip
    logic signed [65:0] s6_sum;
    logic signed [63:0] s6_num;
    logic [63:0]        s6_nm;
    logic               s6_clip;
    hfmc_pkg::t_sq_tag  n6_tag;

    always_comb begin
        s6_sum = {{2{r5_t[0][63]}}, r5_t[0]} - {{2{r5_t[1][63]}}, r5_t[1]}
               + {{2{r5_t[2][63]}}, r5_t[2]};
        s6_clip = 1'b0;
        if (s6_sum > S63_MAX) begin
            s6_num  = S63_MAX[63:0];
            s6_clip = 1'b1;
        end else if (s6_sum < S63_NEG) begin
            s6_num  = S63_NEG[63:0];
            s6_clip = 1'b1;
        end else begin
            s6_num = s6_sum[63:0];
        end
        s6_nm          = s6_num[63] ? (~s6_num + 64'd1) : s6_num;
        n6_tag.num_pos = !s6_num[63] && (s6_num != 64'sd0);
        n6_tag.sat     = r5_sat | s6_clip;
        n6_tag.nm      = s6_nm[62:0];
        n6_tag.pq      = r5_p2[63:FB];
    end

    logic              r6_v;
    logic [63:0]       r6_p2;
    hfmc_pkg::t_sq_tag r6_tag;

    logic              sq_v;
    logic [31:0]       sq_root;
    hfmc_pkg::t_sq_tag sq_tag;

    hfmc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_rad   (r6_p2),
        .i_tag   (r6_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    // stages 7-9: denominator p*sqrt(p), range check, divider setup
    logic [63:0]       r7_dhi;
    logic [47:0]       r7_dlo;
    hfmc_pkg::t_sq_tag r7_tag;
    logic [63:0]       r8_den;
    hfmc_pkg::t_sq_tag r8_tag;

    logic               r9_v;
    logic [63:0]        r9_den;
    logic [63:0]        r9_rem;
    logic [31:0]        r9_low;
    hfmc_pkg::t_div_tag r9_tag;

    logic               r1_v, r2_v, r3_v, r4_v, r5_v, r7_v, r8_v;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 5; i++) begin
            r1_h[i] <= n1_h[i];
        end
        r1_sat <= |n1_clip;

        r2_hx2      <= s2_m[0] * s2_m[0];
        r2_hy2      <= s2_m[1] * s2_m[1];
        r2_hxhy     <= s2_m[0] * s2_m[1];
        r2_hxhy_neg <= r1_h[0][31] ^ r1_h[1][31];
        for (int i = 0; i < 3; i++) begin
            r2_m[i]   <= s2_m[i+2];
            r2_neg[i] <= r1_h[i+2][31];
        end
        r2_sat <= r1_sat;

        r3_p2     <= (64'd1 << (2 * FB)) + r2_hx2 + r2_hy2;
        r3_a[0]   <= 47'((64'd1 << FB) + (r2_hy2 >> FB));
        r3_a[1]   <= 47'(r2_hxhy >> FB);
        r3_a[2]   <= 47'((64'd1 << FB) + (r2_hx2 >> FB));
        r3_neg[0] <= r2_neg[0];
        r3_neg[1] <= r2_hxhy_neg ^ r2_neg[1];
        r3_neg[2] <= r2_neg[2];
        for (int i = 0; i < 3; i++) begin
            r3_m[i] <= r2_m[i];
        end
        r3_sat <= r2_sat;

        for (int i = 0; i < 3; i++) begin
            r4_pph[i] <= r3_a[i][46:16] * r3_m[i];
            r4_ppl[i] <= r3_a[i][15:0] * r3_m[i];
            r4_neg[i] <= r3_neg[i];
        end
        r4_p2  <= r3_p2;
        r4_sat <= r3_sat;

        for (int i = 0; i < 3; i++) begin
            r5_t[i] <= n5_t[i];
        end
        r5_p2  <= r4_p2;
        r5_sat <= r4_sat;

        r6_p2  <= r5_p2;
        r6_tag <= n6_tag;

        r7_dhi <= sq_tag.pq[47:16] * sq_root;
        r7_dlo <= sq_tag.pq[15:0] * sq_root;
        r7_tag <= sq_tag;

        r8_den <= r7_dhi + 64'(r7_dlo >> FB);
        r8_tag <= r7_tag;

        r9_den         <= r8_den;
        r9_rem         <= 64'(r8_tag.nm[62:16]);
        r9_low         <= {r8_tag.nm[15:0], 16'd0};
        r9_tag.num_pos <= r8_tag.num_pos;
        r9_tag.sat     <= r8_tag.sat;
        r9_tag.big     <= {17'd0, r8_tag.nm} >= {r8_den, 16'd0};
        r9_tag.pq      <= r8_tag.pq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else begin
            r1_v <= i_start;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= sq_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    logic               dv_v;
    logic [31:0]        dv_q;
    hfmc_pkg::t_div_tag dv_tag;

    hfmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_v),
        .i_den   (r9_den),
        .i_rem   (r9_rem),
        .i_low   (r9_low),
        .i_tag   (r9_tag),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_tag   (dv_tag)
    );

    // output: sign, clip, flag
    logic [31:0] n_curv;
    logic [31:0] n_slope;
    logic        n_sat;

    always_comb begin
        n_sat = dv_tag.sat;
        if (dv_tag.num_pos) begin
            if (dv_tag.big || (dv_q > 32'h8000_0000)) begin
                n_curv = 32'h8000_0000;
                n_sat  = 1'b1;
            end else begin
                n_curv = ~dv_q + 32'd1;
            end
        end else begin
            if (dv_tag.big || (dv_q > 32'h7FFF_FFFF)) begin
                n_curv = 32'h7FFF_FFFF;
                n_sat  = 1'b1;
            end else begin
                n_curv = dv_q;
            end
        end
        if (|dv_tag.pq[47:32]) begin
            n_slope = 32'hFFFF_FFFF;
            n_sat   = 1'b1;
        end else begin
            n_slope = dv_tag.pq[31:0];
        end
    end

    logic        r_done;
    logic [31:0] r_curv;
    logic [31:0] r_slope;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        r_curv  <= n_curv;
        r_slope <= n_slope;
        r_sat   <= n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_v;
        end
    end

    assign o_done         = r_done;
    assign o_curvature    = r_curv;
    assign o_slope_factor = r_slope;
    assign o_saturated    = r_sat;

endmodule

// File: rtl/core/hfmc_sqrt.sv
// Pipelined 64-bit floor square root, one result bit per stage, with a side tag.
module hfmc_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [63:0]       i_rad,
    input  hfmc_pkg::t_sq_tag i_tag,
    output logic              o_valid,
    output logic [31:0]       o_root,
    output hfmc_pkg::t_sq_tag o_tag
);

    localparam int STEPS = hfmc_pkg::SQRT_STEPS;

    logic [63:0]       x_rem [STEPS];
    logic [63:0]       x_res [STEPS];
    logic              x_v   [STEPS];
    hfmc_pkg::t_sq_tag x_tag [STEPS];

    logic [63:0]       r_rem [STEPS];
    logic [63:0]       r_res [STEPS];
    logic              r_v   [STEPS];
    hfmc_pkg::t_sq_tag r_tag [STEPS];

    assign x_rem[0] = i_rad;
    assign x_res[0] = '0;
    assign x_v[0]   = i_valid;
    assign x_tag[0] = i_tag;

    genvar s;
    generate
        for (s = 0; s < STEPS; s++) begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
            logic [63:0] trial;
            logic [63:0] n_rem;
            logic [63:0] n_res;

            always_comb begin
                trial = x_res[s] + BIT;
                if (x_rem[s] >= trial) begin
                    n_rem = x_rem[s] - trial;
                    n_res = (x_res[s] >> 1) + BIT;
                end else begin
                    n_rem = x_rem[s];
                    n_res = x_res[s] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_res[s] <= n_res;
                r_tag[s] <= x_tag[s];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else begin
                    r_v[s] <= x_v[s];
                end
            end

            if (s > 0) begin : g_link
                assign x_rem[s] = r_rem[s-1];
                assign x_res[s] = r_res[s-1];
                assign x_v[s]   = r_v[s-1];
                assign x_tag[s] = r_tag[s-1];
            end
        end
    endgenerate

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_res[STEPS-1][31:0];
    assign o_tag   = r_tag[STEPS-1];

endmodule

// File: rtl/core/hfmc_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32-bit quotient with a side tag.
module hfmc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [63:0]        i_den,
    input  logic [63:0]        i_rem,
    input  logic [31:0]        i_low,
    input  hfmc_pkg::t_div_tag i_tag,
    output logic               o_valid,
    output logic [31:0]        o_quo,
    output hfmc_pkg::t_div_tag o_tag
);

    localparam int STEPS = hfmc_pkg::DIV_STEPS;

    logic [63:0]        x_rem [STEPS];
    logic [63:0]        x_den [STEPS];
    logic [31:0]        x_low [STEPS];
    logic [31:0]        x_q   [STEPS];
    logic               x_v   [STEPS];
    hfmc_pkg::t_div_tag x_tag [STEPS];

    logic [63:0]        r_rem [STEPS];
    logic [63:0]        r_den [STEPS];
    logic [31:0]        r_low [STEPS];
    logic [31:0]        r_q   [STEPS];
    logic               r_v   [STEPS];
    hfmc_pkg::t_div_tag r_tag [STEPS];

    assign x_rem[0] = i_rem;
    assign x_den[0] = i_den;
    assign x_low[0] = i_low;
    assign x_q[0]   = '0;
    assign x_v[0]   = i_valid;
    assign x_tag[0] = i_tag;

    genvar s;
    generate
        for (s = 0; s < STEPS; s++) begin : g_step
            logic [64:0] shifted;
            logic [63:0] n_rem;
            logic        qbit;

            always_comb begin
                shifted = {x_rem[s], x_low[s][31]};
                if (shifted >= {1'b0, x_den[s]}) begin
                    n_rem = 64'(shifted - {1'b0, x_den[s]});
                    qbit  = 1'b1;
                end else begin
                    n_rem = shifted[63:0];
                    qbit  = 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_den[s] <= x_den[s];
                r_low[s] <= {x_low[s][30:0], 1'b0};
                r_q[s]   <= {x_q[s][30:0], qbit};
                r_tag[s] <= x_tag[s];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else begin
                    r_v[s] <= x_v[s];
                end
            end

            if (s > 0) begin : g_link
                assign x_rem[s] = r_rem[s-1];
                assign x_den[s] = r_den[s-1];
                assign x_low[s] = r_low[s-1];
                assign x_q[s]   = r_q[s-1];
                assign x_v[s]   = r_v[s-1];
                assign x_tag[s] = r_tag[s-1];
            end
        end
    endgenerate

    assign o_valid = r_v[STEPS-1];
    assign o_quo   = r_q[STEPS-1];
    assign o_tag   = r_tag[STEPS-1];

endmodule

// File: verif/height_field_mean_curvature_tb.sv
// Self-checking testbench for the height-field mean curvature pipeline.
module height_field_mean_curvature_tb;

    localparam int RW        = hfmc_pkg::RAW_WIDTH_DEF;
    localparam int FB        = hfmc_pkg::FRAC_BITS;
    localparam int LATENCY   = 74;
    localparam int WDOG_MAX  = 2000;
    localparam logic [63:0] S64MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] curv;
        logic [31:0] pfac;
        logic        sat;
    } t_curv_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic                 i_cfg_we = 1'b0;
    logic [4:0]           i_cfg_wdata = '0;
    logic signed [RW-1:0] i_slope_x_raw = '0;
    logic signed [RW-1:0] i_slope_y_raw = '0;
    logic signed [RW-1:0] i_second_xx_raw = '0;
    logic signed [RW-1:0] i_second_xy_raw = '0;
    logic signed [RW-1:0] i_second_yy_raw = '0;
    logic                 o_done;
    logic signed [31:0]   o_curvature;
    logic [31:0]          o_slope_factor;
    logic                 o_saturated;

    logic [4:0] shift_cfg = hfmc_pkg::NORM_SHIFT_RST;
    t_curv_res  curv_expected[$];
    int         mismatches = 0;
    int         idle_pct = 0;
    int         wdog = 0;

    height_field_mean_curvature i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic [63:0] umulq(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] lim, inout logic sat);
        logic [127:0] pr;
        pr = (a * b) >> FB;
        if (pr > {64'd0, lim}) begin
            sat = 1'b1;
            return lim;
        end
        return pr[63:0];
    endfunction

    function automatic logic signed [63:0] smulq(input logic signed [63:0] a,
                                                 input logic signed [63:0] b, inout logic sat);
        logic [63:0] m;
        m = umulq(mag(a), mag(b), S64MAX, sat);
        return (a[63] != b[63]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b, inout logic sat);
        logic signed [64:0] s;
        s = a + b;
        if (s > $signed({1'b0, S64MAX})) begin
            sat = 1'b1;
            return S64MAX;
        end
        if (s < -$signed({1'b0, S64MAX})) begin
            sat = 1'b1;
            return -$signed(S64MAX);
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] normalize(input logic signed [RW-1:0] raw,
                                                     inout logic sat);
        logic signed [63:0] v;
        v = 64'(raw) >>> shift_cfg;
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if (({64'd0, r | (64'd1 << b)} * {64'd0, r | (64'd1 << b)}) <= {64'd0, n})
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic t_curv_res predict_curvature(input logic signed [RW-1:0] f[5]);
        logic sat;
        logic signed [63:0] hx, hy, hxx, hxy, hyy, ax, ay, t1, t2, t3, num;
        logic [63:0] hx2, hy2, p2, pq, root, den, q;
        logic [127:0] qq;
        t_curv_res r;
        sat = 1'b0;
        hx  = normalize(f[0], sat);
        hy  = normalize(f[1], sat);
        hxx = normalize(f[2], sat);
        hxy = normalize(f[3], sat);
        hyy = normalize(f[4], sat);
        hx2 = mag(hx) * mag(hx);
        hy2 = mag(hy) * mag(hy);
        p2 = (64'd1 << (2 * FB)) + hx2 + hy2;
        pq = p2 >> FB;
        root = isqrt(p2);
        ax = (64'd1 << FB) + (hx2 >> FB);
        ay = (64'd1 << FB) + (hy2 >> FB);
        t1 = smulq(ay, hxx, sat);
        t2 = smulq(smulq(hx, hy, sat), hxy, sat);
        t2 = sadd(t2, t2, sat);
        t3 = smulq(ax, hyy, sat);
        num = sadd(sadd(t1, -t2, sat), t3, sat);
        den = umulq(pq, root, '1, sat);
        qq = {64'd0, mag(num)} << FB;
        qq = qq / den;
        q = (qq[127:64] != 0) ? '1 : qq[63:0];
        if (num > 0) begin
            if (q > 64'd2147483648) begin
                sat = 1'b1;
                q = 64'd2147483648;
            end
            r.curv = 32'(-q);
        end else begin
            if (q > 64'd2147483647) begin
                sat = 1'b1;
                q = 64'd2147483647;
            end
            r.curv = q[31:0];
        end
        if (pq > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            pq = 64'hFFFF_FFFF;
        end
        r.pfac = pq[31:0];
        r.sat = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_curv_res got, exp_r;
        if (i_rst_n && o_done) begin
            got = '{o_curvature, o_slope_factor, o_saturated};
            if (curv_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %b", got.curv, got.pfac, got.sat);
            end else begin
                exp_r = curv_expected.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp k=%h p=%h s=%b got k=%h p=%h s=%b",
                                 exp_r.curv, exp_r.pfac, exp_r.sat,
                                 got.curv, got.pfac, got.sat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_point(input logic signed [RW-1:0] f[5]);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_slope_x_raw <= f[0];
        i_slope_y_raw <= f[1];
        i_second_xx_raw <= f[2];
        i_second_xy_raw <= f[3];
        i_second_yy_raw <= f[4];
        do @(posedge i_clk); while (o_busy);
        curv_expected.push_back(predict_curvature(f));
    endtask

    task automatic drain_and_config(input logic [4:0] sh);
        i_start <= 1'b0;
        wait (curv_expected.size() == 0);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= sh;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shift_cfg = sh;
    endtask

    function automatic logic signed [RW-1:0] rand_raw(input int mode);
        logic [RW-1:0] v;
        v = RW'({$urandom, $urandom});
        case (mode)
            0: return v;
            1: return $signed(v[RW-1:0]) >>> $urandom_range(RW - 1);
            default: return $signed(v[23:0]) << $urandom_range(8);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [RW-1:0] f[5];
        logic signed [RW-1:0] ext[6];
        ext = '{{1'b0, {(RW-1){1'b1}}}, {1'b1, {(RW-1){1'b0}}}, '0, '1, 48'sd65536, -48'sd1};
        foreach (ext[a]) begin
            foreach (f[i]) f[i] = ext[a];
            send_point(f);
            foreach (f[i]) f[i] = (i == a % 5) ? ext[a] : '0;
            send_point(f);
        end
        f = '{48'sd65536 <<< 16, -48'sd65536 <<< 16, 48'sd3 <<< 32, -48'sd7 <<< 30, 48'sd1 <<< 40};
        send_point(f);
        f = '{'0, '0, 48'sd131072 <<< 16, '0, 48'sd131072 <<< 16};
        send_point(f);
    endtask

    task automatic test_random(input int n);
        logic signed [RW-1:0] f[5];
        int mode;
        repeat (n) begin
            mode = $urandom_range(2);
            foreach (f[i]) f[i] = rand_raw(mode);
            send_point(f);
        end
    endtask

    task automatic test_shifts();
        logic [4:0] shs[4];
        shs = '{5'd0, 5'd31, 5'd8, 5'd16};
        foreach (shs[s]) begin
            drain_and_config(shs[s]);
            test_directed();
            test_random(60);
        end
    endtask

    task automatic test_idle_phases();
        int pcts[4];
        pcts = '{0, 67, 0, 12};
        foreach (pcts[p]) begin
            idle_pct = pcts[p];
            drain_and_config(5'($urandom_range(31)));
            test_random(160);
        end
        idle_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_shifts();
        test_idle_phases();
        i_start <= 1'b0;
        wait (curv_expected.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
